[hw/rtl/mqt_pkg.sv]
`timescale 1ns / 1ps

package mqt_pkg;

    localparam int SYMBOL_CHARS = 8;
    localparam int TS_W         = 29;
    localparam int PRICE_W      = 48;
    localparam int QTY_W        = 32;

    // entries in the result queue of the top level
    localparam int OUT_QDEPTH   = 3;

    localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
    localparam logic [QTY_W-1:0]   QTY_MAX   = {QTY_W{1'b1}};

    localparam logic [PRICE_W-1:0] PRICE_LIM_X10000 = PRICE_MAX / 48'd10000;
    localparam logic [PRICE_W-1:0] PRICE_LIM_X1000  = PRICE_MAX / 48'd1000;
    localparam logic [PRICE_W-1:0] PRICE_LIM_X100   = PRICE_MAX / 48'd100;
    localparam logic [PRICE_W-1:0] PRICE_LIM_X10    = PRICE_MAX / 48'd10;

    // characters
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_T     = 8'h54;

    // field numbers within a data line
    localparam logic [3:0] FLD_TIME = 4'd0;
    localparam logic [3:0] FLD_TYPE = 4'd1;
    localparam logic [3:0] FLD_SYM  = 4'd2;
    localparam logic [3:0] FLD_P1   = 4'd3;
    localparam logic [3:0] FLD_Q1   = 4'd4;
    localparam logic [3:0] FLD_P2   = 4'd5;
    localparam logic [3:0] FLD_Q2   = 4'd6;
    localparam logic [3:0] FLD_MAX  = 4'd15;
    localparam logic [3:0] POS_MAX  = 4'd15;
    localparam logic [3:0] TIME_POS_END = 4'd12;
    localparam logic [2:0] FRAC_DIGITS  = 3'd4;

    // record kinds
    localparam logic [1:0] KIND_QUOTE = 2'd0;
    localparam logic [1:0] KIND_TRADE = 2'd1;
    localparam logic [1:0] KIND_EOF   = 2'd2;

    // accept_kinds codes; anything else passes both kinds
    localparam logic [1:0] ACC_QUOTES = 2'd0;
    localparam logic [1:0] ACC_TRADES = 2'd1;
    localparam logic [1:0] ACC_BOTH   = 2'd2;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_COMMENT,
        PH_HEADER,
        PH_DATA
    } phase_t;

    typedef enum logic [1:0] {
        ST_PENDING,
        ST_QUOTE,
        ST_TRADE,
        ST_REJECT
    } rtype_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [TS_W-1:0]    ts;
        logic [63:0]        sym;
        logic [PRICE_W-1:0] fp;
        logic [QTY_W-1:0]   fq;
        logic [PRICE_W-1:0] sp;
        logic [QTY_W-1:0]   sq;
        logic               last;
    } rec_t;

    typedef struct packed {
        logic rec_valid;
        logic eof_valid;
        rec_t rec;
    } emit_t;

    // millisecond weight of each character position of HH:MM:SS.mmm
    function automatic logic [25:0] time_weight(input logic [3:0] pos);
        logic [25:0] w;
        case (pos)
            4'd0:    w = 26'd36000000;
            4'd1:    w = 26'd3600000;
            4'd3:    w = 26'd600000;
            4'd4:    w = 26'd60000;
            4'd6:    w = 26'd10000;
            4'd7:    w = 26'd1000;
            4'd9:    w = 26'd100;
            4'd10:   w = 26'd10;
            4'd11:   w = 26'd1;
            default: w = 26'd0;
        endcase
        return w;
    endfunction

    function automatic logic [13:0] price_scale(input logic [2:0] frac);
        logic [13:0] s;
        case (frac)
            3'd0:    s = 14'd10000;
            3'd1:    s = 14'd1000;
            3'd2:    s = 14'd100;
            3'd3:    s = 14'd10;
            default: s = 14'd1;
        endcase
        return s;
    endfunction

    function automatic logic [PRICE_W-1:0] price_limit(input logic [2:0] frac);
        logic [PRICE_W-1:0] l;
        case (frac)
            3'd0:    l = PRICE_LIM_X10000;
            3'd1:    l = PRICE_LIM_X1000;
            3'd2:    l = PRICE_LIM_X100;
            3'd3:    l = PRICE_LIM_X10;
            default: l = PRICE_MAX;
        endcase
        return l;
    endfunction

    function automatic logic is_price_field(input rtype_t rt, input logic [3:0] f);
        logic r;
        case (rt)
            ST_QUOTE: r = (f == FLD_P1) || (f == FLD_P2);
            ST_TRADE: r = (f == FLD_P1);
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_qty_field(input rtype_t rt, input logic [3:0] f);
        logic r;
        case (rt)
            ST_QUOTE: r = (f == FLD_Q1) || (f == FLD_Q2);
            ST_TRADE: r = (f == FLD_Q1);
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/mqt_parse.sv]
`timescale 1ns / 1ps

module mqt_parse (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    input  logic                 in_eof,
    input  logic [1:0]           accept_kinds,
    output mqt_pkg::emit_t       emit
);

    mqt_pkg::phase_t phase_reg, phase_next;
    logic            end_reg, end_next;

    logic [3:0]                  fld_reg, fld_next;
    logic [3:0]                  pos_reg, pos_next;
    logic [mqt_pkg::TS_W-1:0]    ts_reg, ts_next;
    mqt_pkg::rtype_t             rtype_reg, rtype_next;
    logic [7:0][7:0]             sym_reg, sym_next;
    logic [3:0]                  symlen_reg, symlen_next;
    logic [mqt_pkg::PRICE_W-1:0] pacc_reg, pacc_next;
    logic [2:0]                  frac_reg, frac_next;
    logic                        point_reg, point_next;
    logic [mqt_pkg::QTY_W-1:0]   qacc_reg, qacc_next;
    logic                        qstop_reg, qstop_next;
    logic [mqt_pkg::PRICE_W-1:0] hfp_reg, hfp_next;
    logic [mqt_pkg::QTY_W-1:0]   hfq_reg, hfq_next;
    logic [mqt_pkg::PRICE_W-1:0] hsp_reg, hsp_next;
    logic                        skip_reg, skip_next;

    logic                        live;
    logic                        is_digit;
    logic                        is_comma;
    logic [3:0]                  dig;
    logic [3:0]                  fld_inc;
    logic [3:0]                  pos_inc;
    logic [29:0]                 tprod;
    logic [61:0]                 pprod;
    logic [mqt_pkg::PRICE_W-1:0] pv;
    logic [51:0]                 pstep;
    logic [35:0]                 qstep;
    logic                        rec_ok;
    logic                        line_clr;
    mqt_pkg::rec_t               rec;

    assign live     = in_valid && !end_reg;
    assign is_digit = (in_byte >= mqt_pkg::CH_0) && (in_byte <= mqt_pkg::CH_9);
    assign is_comma = (in_byte == mqt_pkg::CH_COMMA);
    assign dig      = is_digit ? 4'(in_byte - mqt_pkg::CH_0) : 4'd0;
    assign fld_inc  = (fld_reg == mqt_pkg::FLD_MAX) ? fld_reg : fld_reg + 4'd1;
    assign pos_inc  = (pos_reg == mqt_pkg::POS_MAX) ? pos_reg : pos_reg + 4'd1;

    // digit contribution of the time field, and the price scaled to four fraction digits
    assign tprod = 30'(dig) * 30'(mqt_pkg::time_weight(pos_reg));
    assign pprod = pacc_reg * mqt_pkg::price_scale(frac_reg);
    assign pv    = (pacc_reg > mqt_pkg::price_limit(frac_reg)) ? mqt_pkg::PRICE_MAX
                                                                 : pprod[mqt_pkg::PRICE_W-1:0];
    assign pstep = {1'b0, pacc_reg, 3'b000} + {3'b000, pacc_reg, 1'b0} + 52'(dig);
    assign qstep = {1'b0, qacc_reg, 3'b000} + {3'b000, qacc_reg, 1'b0} + 36'(dig);

    assign rec_ok = ((rtype_reg == mqt_pkg::ST_QUOTE) && (accept_kinds != mqt_pkg::ACC_TRADES))
                 || ((rtype_reg == mqt_pkg::ST_TRADE) && (accept_kinds != mqt_pkg::ACC_QUOTES));

    // record of the line now ending, with the open field folded in
    always_comb begin
        rec      = '0;
        rec.ts   = ts_reg;
        rec.sym  = sym_reg;
        rec.last = !in_eof;
        rec.fp   = (fld_reg == mqt_pkg::FLD_P1) ? pv : hfp_reg;
        if (rtype_reg == mqt_pkg::ST_QUOTE) begin
            rec.kind = mqt_pkg::KIND_QUOTE;
            rec.fq   = (fld_reg == mqt_pkg::FLD_Q1) ? qacc_reg : hfq_reg;
            rec.sp   = (fld_reg == mqt_pkg::FLD_P2) ? pv : hsp_reg;
            rec.sq   = (fld_reg >= mqt_pkg::FLD_Q2) ? qacc_reg : '0;
        end else begin
            rec.kind = mqt_pkg::KIND_TRADE;
            rec.fq   = (fld_reg >= mqt_pkg::FLD_Q1) ? qacc_reg : '0;
        end
    end

    // file phase next state
    always_comb begin
        phase_next = phase_reg;
        if (live && !in_eof) begin
            case (phase_reg)
                mqt_pkg::PH_LEAD: begin
                    if (in_byte == mqt_pkg::CH_HASH) begin
                        phase_next = mqt_pkg::PH_COMMENT;
                    end else if (in_byte != mqt_pkg::CH_NL) begin
                        phase_next = mqt_pkg::PH_HEADER;
                    end
                end
                mqt_pkg::PH_COMMENT: begin
                    if (in_byte == mqt_pkg::CH_NL) begin
                        phase_next = mqt_pkg::PH_LEAD;
                    end
                end
                mqt_pkg::PH_HEADER: begin
                    if (in_byte == mqt_pkg::CH_NL) begin
                        phase_next = mqt_pkg::PH_DATA;
                    end
                end
                default: begin
                    phase_next = mqt_pkg::PH_DATA;
                end
            endcase
        end
    end

    // line datapath and results
    always_comb begin
        end_next    = end_reg;
        fld_next    = fld_reg;
        pos_next    = pos_reg;
        ts_next     = ts_reg;
        rtype_next  = rtype_reg;
        sym_next    = sym_reg;
        symlen_next = symlen_reg;
        pacc_next   = pacc_reg;
        frac_next   = frac_reg;
        point_next  = point_reg;
        qacc_next   = qacc_reg;
        qstop_next  = qstop_reg;
        hfp_next    = hfp_reg;
        hfq_next    = hfq_reg;
        hsp_next    = hsp_reg;
        skip_next   = skip_reg;
        emit        = '0;
        emit.rec    = rec;
        line_clr    = 1'b0;

        if (live) begin
            if (in_eof) begin
                end_next       = 1'b1;
                emit.eof_valid = 1'b1;
                emit.rec_valid = (phase_reg == mqt_pkg::PH_DATA) && rec_ok;
            end else if (phase_reg == mqt_pkg::PH_HEADER) begin
                line_clr = (in_byte == mqt_pkg::CH_NL);
            end else if (phase_reg == mqt_pkg::PH_DATA) begin
                if (in_byte == mqt_pkg::CH_NL) begin
                    emit.rec_valid = rec_ok;
                    line_clr       = 1'b1;
                end else if (rtype_reg != mqt_pkg::ST_REJECT
                             && !(skip_reg && is_comma)) begin
                    skip_next = 1'b0;
                    if (is_comma) begin
                        // close the field: latch price or quantity it carried
                        if (fld_reg == mqt_pkg::FLD_P1) begin
                            hfp_next = pv;
                        end
                        if (rtype_reg == mqt_pkg::ST_QUOTE) begin
                            if (fld_reg == mqt_pkg::FLD_Q1) begin
                                hfq_next = qacc_reg;
                            end
                            if (fld_reg == mqt_pkg::FLD_P2) begin
                                hsp_next = pv;
                            end
                        end
                        if (fld_reg == mqt_pkg::FLD_TYPE
                            && rtype_reg == mqt_pkg::ST_PENDING) begin
                            rtype_next = mqt_pkg::ST_REJECT;
                        end else begin
                            fld_next = fld_inc;
                            pos_next = 4'd0;
                            if (mqt_pkg::is_price_field(rtype_reg, fld_inc)) begin
                                pacc_next  = '0;
                                frac_next  = 3'd0;
                                point_next = 1'b0;
                            end
                            if (mqt_pkg::is_qty_field(rtype_reg, fld_inc)) begin
                                qacc_next  = '0;
                                qstop_next = 1'b0;
                            end
                            if (rtype_reg == mqt_pkg::ST_TRADE
                                && fld_inc == mqt_pkg::FLD_P1) begin
                                skip_next = 1'b1;
                            end
                        end
                    end else if (fld_reg == mqt_pkg::FLD_TIME) begin
                        if (pos_reg < mqt_pkg::TIME_POS_END) begin
                            ts_next = ts_reg + tprod[mqt_pkg::TS_W-1:0];
                        end
                        pos_next = pos_inc;
                    end else if (fld_reg == mqt_pkg::FLD_TYPE) begin
                        if (pos_reg != 4'd0) begin
                            rtype_next = mqt_pkg::ST_REJECT;
                        end else if (in_byte == mqt_pkg::CH_Q) begin
                            rtype_next = mqt_pkg::ST_QUOTE;
                        end else if (in_byte == mqt_pkg::CH_T) begin
                            rtype_next = mqt_pkg::ST_TRADE;
                        end else begin
                            rtype_next = mqt_pkg::ST_REJECT;
                        end
                        pos_next = pos_inc;
                    end else if (fld_reg == mqt_pkg::FLD_SYM) begin
                        if (symlen_reg < 4'(mqt_pkg::SYMBOL_CHARS)) begin
                            sym_next[symlen_reg[2:0]] = in_byte;
                            symlen_next = symlen_reg + 4'd1;
                        end
                    end else if (mqt_pkg::is_price_field(rtype_reg, fld_reg)) begin
                        if (in_byte == mqt_pkg::CH_DOT) begin
                            point_next = 1'b1;
                        end else if (!(point_reg && frac_reg >= mqt_pkg::FRAC_DIGITS)
                                     && is_digit) begin
                            pacc_next = (pstep[51:mqt_pkg::PRICE_W] != '0)
                                      ? mqt_pkg::PRICE_MAX : pstep[mqt_pkg::PRICE_W-1:0];
                            if (point_reg) begin
                                frac_next = frac_reg + 3'd1;
                            end
                        end
                    end else if (mqt_pkg::is_qty_field(rtype_reg, fld_reg)) begin
                        if (!qstop_reg) begin
                            if (!is_digit) begin
                                qstop_next = 1'b1;
                            end else begin
                                qacc_next = (qstep[35:mqt_pkg::QTY_W] != '0)
                                          ? mqt_pkg::QTY_MAX : qstep[mqt_pkg::QTY_W-1:0];
                            end
                        end
                    end
                end
            end
        end

        if (line_clr) begin
            fld_next    = '0;
            pos_next    = '0;
            ts_next     = '0;
            rtype_next  = mqt_pkg::ST_PENDING;
            sym_next    = '0;
            symlen_next = '0;
            pacc_next   = '0;
            frac_next   = '0;
            point_next  = 1'b0;
            qacc_next   = '0;
            qstop_next  = 1'b0;
            hfp_next    = '0;
            hfq_next    = '0;
            hsp_next    = '0;
            skip_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mqt_pkg::PH_LEAD;
            end_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            end_reg   <= end_next;
        end
    end

    // line state is cleared when the header line ends, before any data is parsed
    always_ff @(posedge aclk) begin
        fld_reg    <= fld_next;
        pos_reg    <= pos_next;
        ts_reg     <= ts_next;
        rtype_reg  <= rtype_next;
        sym_reg    <= sym_next;
        symlen_reg <= symlen_next;
        pacc_reg   <= pacc_next;
        frac_reg   <= frac_next;
        point_reg  <= point_next;
        qacc_reg   <= qacc_next;
        qstop_reg  <= qstop_next;
        hfp_reg    <= hfp_next;
        hfq_reg    <= hfq_next;
        hsp_reg    <= hsp_next;
        skip_reg   <= skip_next;
    end

endmodule

[hw/rtl/market_quote_trade_csv_parser.sv]
`timescale 1ns / 1ps

// Market-data CSV parser for quote and trade lines. Feed the file one byte per
// transaction on the slave stream, then one transaction with s_tuser high to mark
// end of file. Leading empty and '#' lines and the header line are skipped; each
// data line whose second field is exactly Q or T becomes one record on the master
// stream when its newline (or end of file) arrives, filtered by cfg_data
// (0 quotes only, 1 trades only, 2 or 3 both). End of file always yields a final
// marker with kind 2 and tlast high. The parser takes one byte per clock: all
// per-byte work is a single registered pass, and results go into a three-entry
// output queue, so s_tready stays high as long as at most one result is waiting.
// After end of file, bytes are still accepted and dropped until reset. Write the
// configuration only while the block is idle; there is no clearing pass after reset.
module market_quote_trade_csv_parser (
    input  logic         aclk,
    input  logic         aresetn,

    // configuration: accept_kinds
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_data,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] end_of_file

    output logic         m_tvalid,
    input  logic         m_tready,
    // [28:0] timestamp_ms, [92:29] symbol_chars, [140:93] first_price,
    // [172:141] first_quantity, [220:173] second_price, [252:221] second_quantity,
    // [255:253] zero
    output logic [255:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] record_kind
    output logic         m_tlast    // last_of_run
);

    logic [1:0]     accept_kinds_reg;
    logic [1:0]     count_reg, count_next;
    mqt_pkg::rec_t  q_reg [mqt_pkg::OUT_QDEPTH];
    mqt_pkg::rec_t  q_next [mqt_pkg::OUT_QDEPTH];
    mqt_pkg::emit_t emit;
    mqt_pkg::rec_t  marker;
    logic           s_acc;
    logic           pop;
    logic [1:0]     wr_idx;

    assign cfg_ready = 1'b1;
    assign s_tready  = (count_reg < 2'd2);
    assign s_acc     = s_tvalid && s_tready;
    assign m_tvalid  = (count_reg != 2'd0);
    assign pop       = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accept_kinds_reg <= mqt_pkg::ACC_BOTH;
        end else if (cfg_valid && cfg_ready) begin
            accept_kinds_reg <= cfg_data;
        end
    end

    mqt_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_acc),
        .in_byte      (s_tdata),
        .in_eof       (s_tuser),
        .accept_kinds (accept_kinds_reg),
        .emit         (emit)
    );

    // end-of-file marker: kind 2, tlast high, everything else zero
    always_comb begin
        marker      = '0;
        marker.kind = mqt_pkg::KIND_EOF;
        marker.last = 1'b1;
    end

    // output queue: head at entry 0; shift down on pop, then append up to two results
    always_comb begin
        q_next = q_reg;
        if (pop) begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
        end
        wr_idx = count_reg - 2'(pop);
        if (emit.rec_valid) begin
            q_next[wr_idx] = emit.rec;
        end
        if (emit.eof_valid) begin
            q_next[wr_idx + 2'(emit.rec_valid)] = marker;
        end
        count_next = wr_idx + 2'(emit.rec_valid) + 2'(emit.eof_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // hold payload; only the count needs reset
    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign m_tdata = {3'b000, q_reg[0].sq, q_reg[0].sp, q_reg[0].fq,
                      q_reg[0].fp, q_reg[0].sym, q_reg[0].ts};
    assign m_tuser = q_reg[0].kind;
    assign m_tlast = q_reg[0].last;

endmodule

[tb/market_quote_trade_csv_checker.sv]
`timescale 1ns / 1ps

// Watches the config, input and result streams of the CSV parser, predicts the
// records of each accepted byte and compares them in order.
module market_quote_trade_csv_checker
    import mqt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [255:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         m_tlast,
    output int           mismatches,
    output int           outstanding
);

    rec_t expected_recs[$];

    // parser state as seen from the byte stream
    phase_t       file_stage;
    logic         end_done;
    logic [1:0]   kind_filter;
    logic         line_seen;
    logic [3:0]   fld;
    logic [3:0]   pos;
    logic [3:0]   time_dig [0:8];
    rtype_t       line_type;
    logic [63:0]  sym_buf;
    logic [3:0]   sym_len;
    logic [47:0]  px_acc;
    logic [2:0]   px_frac;
    logic         px_dot;
    logic [31:0]  qty_acc;
    logic         qty_done;
    logic [47:0]  hold_px1;
    logic [47:0]  hold_px2;
    logic [31:0]  hold_qty1;
    logic         comma_skip;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic price_slot(input rtype_t t, input logic [3:0] f);
        case (t)
            ST_QUOTE: return (f == FLD_P1) || (f == FLD_P2);
            ST_TRADE: return f == FLD_P1;
            default:  return 1'b0;
        endcase
    endfunction

    function automatic logic qty_slot(input rtype_t t, input logic [3:0] f);
        case (t)
            ST_QUOTE: return (f == FLD_Q1) || (f == FLD_Q2);
            ST_TRADE: return f == FLD_Q1;
            default:  return 1'b0;
        endcase
    endfunction

    // digit slot of a character position in HH:MM:SS.mmm, -1 for separators
    function automatic int time_slot(input logic [3:0] p);
        case (p)
            4'd0:    return 0;
            4'd1:    return 1;
            4'd3:    return 2;
            4'd4:    return 3;
            4'd6:    return 4;
            4'd7:    return 5;
            4'd9:    return 6;
            4'd10:   return 7;
            4'd11:   return 8;
            default: return -1;
        endcase
    endfunction

    function automatic logic [28:0] time_ms();
        int d [0:8];
        int ms;
        foreach (d[i]) d[i] = time_dig[i];
        ms = ((((d[0] * 10 + d[1]) * 60 + d[2] * 10 + d[3]) * 60 + d[4] * 10 + d[5]) * 1000)
             + d[6] * 100 + d[7] * 10 + d[8];
        return ms[28:0];
    endfunction

    // scale to four fraction digits, saturating
    function automatic logic [47:0] scaled_price();
        logic [63:0] v;
        v = {16'd0, px_acc};
        for (int f = px_frac; f < FRAC_DIGITS; f++) begin
            v = v * 64'd10;
            if (v > PRICE_MAX) v = PRICE_MAX;
        end
        return v[47:0];
    endfunction

    task automatic restart_line();
        line_seen  = 1'b0;
        fld        = '0;
        pos        = '0;
        foreach (time_dig[i]) time_dig[i] = '0;
        line_type  = ST_PENDING;
        sym_buf    = '0;
        sym_len    = '0;
        px_acc     = '0;
        px_frac    = '0;
        px_dot     = 1'b0;
        qty_acc    = '0;
        qty_done   = 1'b0;
        hold_px1   = '0;
        hold_px2   = '0;
        hold_qty1  = '0;
        comma_skip = 1'b0;
    endtask

    task automatic close_field();
        if (line_type == ST_QUOTE) begin
            if (fld == FLD_P1) hold_px1 = scaled_price();
            else if (fld == FLD_Q1) hold_qty1 = qty_acc;
            else if (fld == FLD_P2) hold_px2 = scaled_price();
        end else if (line_type == ST_TRADE && fld == FLD_P1) begin
            hold_px1 = scaled_price();
        end
    endtask

    task automatic time_byte(input logic [7:0] b);
        int s;
        s = time_slot(pos);
        if (s >= 0) time_dig[s] = is_digit(b) ? 4'(b - CH_0) : 4'd0;
        if (pos < POS_MAX) pos++;
    endtask

    task automatic price_byte(input logic [7:0] b);
        logic [63:0] v;
        if (b == CH_DOT) begin
            px_dot = 1'b1;
        end else if (!(px_dot && px_frac >= FRAC_DIGITS) && is_digit(b)) begin
            v = {16'd0, px_acc} * 64'd10 + 64'(b - CH_0);
            if (v > PRICE_MAX) v = PRICE_MAX;
            px_acc = v[47:0];
            if (px_dot) px_frac++;
        end
    endtask

    task automatic qty_byte(input logic [7:0] b);
        logic [63:0] v;
        if (!qty_done) begin
            if (!is_digit(b)) begin
                qty_done = 1'b1;
            end else begin
                v = {32'd0, qty_acc} * 64'd10 + 64'(b - CH_0);
                if (v > QTY_MAX) v = QTY_MAX;
                qty_acc = v[31:0];
            end
        end
    endtask

    task automatic line_byte(input logic [7:0] b);
        line_seen = 1'b1;
        if (line_type == ST_REJECT) return;
        if (comma_skip) begin
            if (b == CH_COMMA) return;
            comma_skip = 1'b0;
        end
        if (b == CH_COMMA) begin
            close_field();
            // an empty type field rejects the line
            if (fld == FLD_TYPE && line_type == ST_PENDING) begin
                line_type = ST_REJECT;
                return;
            end
            if (fld < FLD_MAX) fld++;
            pos = '0;
            if (price_slot(line_type, fld)) begin
                px_acc  = '0;
                px_frac = '0;
                px_dot  = 1'b0;
            end
            if (qty_slot(line_type, fld)) begin
                qty_acc  = '0;
                qty_done = 1'b0;
            end
            if (line_type == ST_TRADE && fld == FLD_P1) comma_skip = 1'b1;
            return;
        end
        if (fld == FLD_TIME) begin
            time_byte(b);
        end else if (fld == FLD_TYPE) begin
            if (pos == 0) begin
                if (b == CH_Q) line_type = ST_QUOTE;
                else if (b == CH_T) line_type = ST_TRADE;
                else line_type = ST_REJECT;
            end else begin
                line_type = ST_REJECT;
            end
            if (pos < POS_MAX) pos++;
        end else if (fld == FLD_SYM) begin
            if (sym_len < SYMBOL_CHARS) begin
                sym_buf[8 * sym_len +: 8] = b;
                sym_len++;
            end
        end else if (price_slot(line_type, fld)) begin
            price_byte(b);
        end else if (qty_slot(line_type, fld)) begin
            qty_byte(b);
        end
    endtask

    task automatic finish_line(output logic emit, output rec_t r);
        emit = 1'b0;
        r    = '0;
        if (line_seen && (line_type == ST_QUOTE || line_type == ST_TRADE)) begin
            close_field();
            r.ts  = time_ms();
            r.sym = sym_buf;
            r.fp  = hold_px1;
            if (line_type == ST_QUOTE && kind_filter != ACC_TRADES) begin
                r.kind = KIND_QUOTE;
                r.fq   = hold_qty1;
                r.sp   = hold_px2;
                r.sq   = (fld >= FLD_Q2) ? qty_acc : '0;
                emit   = 1'b1;
            end else if (line_type == ST_TRADE && kind_filter != ACC_QUOTES) begin
                r.kind = KIND_TRADE;
                r.fq   = (fld >= FLD_Q1) ? qty_acc : '0;
                emit   = 1'b1;
            end
        end
        restart_line();
    endtask

    task automatic predict_item(input logic [7:0] b, input logic eof);
        logic emit;
        rec_t r;
        if (end_done) return;
        if (eof) begin
            if (file_stage == PH_DATA) begin
                finish_line(emit, r);
                if (emit) expected_recs.push_back(r);
            end
            r      = '0;
            r.kind = KIND_EOF;
            r.last = 1'b1;
            expected_recs.push_back(r);
            end_done = 1'b1;
            return;
        end
        case (file_stage)
            PH_LEAD: begin
                if (b == CH_HASH) file_stage = PH_COMMENT;
                else if (b != CH_NL) file_stage = PH_HEADER;
            end
            PH_COMMENT: begin
                if (b == CH_NL) file_stage = PH_LEAD;
            end
            PH_HEADER: begin
                if (b == CH_NL) begin
                    file_stage = PH_DATA;
                    restart_line();
                end
            end
            default: begin
                if (b == CH_NL) begin
                    finish_line(emit, r);
                    if (emit) begin
                        r.last = 1'b1;
                        expected_recs.push_back(r);
                    end
                end else begin
                    line_byte(b);
                end
            end
        endcase
    endtask

    task automatic log_mismatch(input string msg);
        mismatches++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) log_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task automatic check_result();
        rec_t want;
        if (expected_recs.size() == 0) begin
            log_mismatch($sformatf("result of kind %0d with nothing expected", m_tuser));
            return;
        end
        want = expected_recs.pop_front();
        check_field("record_kind", m_tuser, want.kind);
        check_field("timestamp_ms", m_tdata[28:0], want.ts);
        check_field("symbol_chars", m_tdata[92:29], want.sym);
        check_field("first_price", m_tdata[140:93], want.fp);
        check_field("first_quantity", m_tdata[172:141], want.fq);
        check_field("second_price", m_tdata[220:173], want.sp);
        check_field("second_quantity", m_tdata[252:221], want.sq);
        check_field("tdata padding", m_tdata[255:253], 64'd0);
        check_field("last_of_run", m_tlast, want.last);
    endtask

    // results first: nothing accepted at this edge can already be on the output
    always @(posedge aclk) begin
        if (!aresetn) begin
            file_stage  = PH_LEAD;
            end_done    = 1'b0;
            kind_filter = ACC_BOTH;
            restart_line();
            expected_recs.delete();
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (cfg_valid && cfg_ready) kind_filter = cfg_data;
            if (s_tvalid && s_tready) predict_item(s_tdata, s_tuser);
        end
        outstanding = expected_recs.size();
    end

endmodule

[tb/market_quote_trade_csv_parser_tb.sv]
`timescale 1ns / 1ps

module market_quote_trade_csv_parser_tb;
    import mqt_pkg::*;

    // any code above 2 passes both kinds
    localparam logic [1:0] ACC_ANY = 2'd3;
    // cycles for the registered pass and output queue to settle after the last record
    localparam int SETTLE_CYCLES = 16;
    // receiver hold-off that fills the output queue and stalls s_tready
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_BYTES = 140;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [255:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    int mismatches;
    int outstanding;

    // no random idling on either side while set
    logic quiet_run;
    // one-shot request for the receiver's long hold-off
    logic hold_off_req;

    logic [7:0] file_bytes[$];
    logic [1:0] filter_plan [0:7];

    market_quote_trade_csv_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    market_quote_trade_csv_checker feed_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: drive m_tready at the falling edge; ~30% idle unless quiet.
    // On request, hold off for a long stretch so the block backs up.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready <= quiet_run || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    function automatic string digit_string(input int n);
        string s;
        s = "";
        repeat (n) s = $sformatf("%s%c", s, 8'd48 + 8'($urandom_range(0, 9)));
        return s;
    endfunction

    // integer part, optional point and fraction; rarely too wide or with junk
    function automatic string price_text();
        string s;
        int ip;
        ip = ($urandom_range(0, 19) == 0) ? 16 : $urandom_range(0, 5);
        s = digit_string(ip);
        if ($urandom_range(0, 3) != 0) s = {s, ".", digit_string($urandom_range(0, 6))};
        if ($urandom_range(0, 15) == 0) s = {s, "x.", digit_string(2)};
        return s;
    endfunction

    function automatic string qty_text();
        string s;
        s = digit_string(($urandom_range(0, 15) == 0) ? 11 : $urandom_range(0, 5));
        if ($urandom_range(0, 9) == 0) s = {s, "k9"};
        return s;
    endfunction

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
    endtask

    // Mostly well-formed quotes and trades with random content; the rest is
    // rejected types, empty lines and raw noise.
    task automatic append_random_line();
        string ts;
        string sym;
        string ln;
        string charset;
        int pick;
        int n;
        logic [7:0] b;
        charset = "0123456789:.ab";
        if ($urandom_range(0, 9) != 0) begin
            ts = $sformatf("%s:%s:%s.%s", digit_string(2), digit_string(2), digit_string(2),
                           digit_string(3));
        end else begin
            ts = "";
            repeat ($urandom_range(0, 14)) ts = {ts, string'(charset[$urandom_range(0, 13)])};
        end
        sym = "";
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 6);
        repeat (n) begin
            b = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(128, 255))
                                              : 8'($urandom_range(65, 90));
            sym = $sformatf("%s%c", sym, b);
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            ln = {ts, ",Q,", sym};
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 4;
            for (int i = 0; i < n; i++) ln = {ln, ",", (i % 2 == 0) ? price_text() : qty_text()};
            if ($urandom_range(0, 7) == 0) ln = {ln, ",", digit_string(3), ",x"};
        end else if (pick < 80) begin
            ln = {ts, ",T,", sym};
            repeat ($urandom_range(0, 3)) ln = {ln, ","};
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : 2;
            for (int i = 0; i < n; i++) ln = {ln, ",", (i == 0) ? price_text() : qty_text()};
            if ($urandom_range(0, 7) == 0) ln = {ln, ",", digit_string(3), ",x"};
        end else if (pick < 88) begin
            case ($urandom_range(0, 4))
                0:       ln = {ts, ",,", sym, ",1,2"};
                1:       ln = {ts, ",QQ,", sym, ",1,2"};
                2:       ln = {ts, ",t,", sym, ",1,2"};
                3:       ln = {ts, ",TQ,", sym, ",1,2"};
                default: ln = {ts, ",X,", sym, ",1,2"};
            endcase
        end else if (pick < 93) begin
            ln = "";
        end else begin
            // raw bytes of any value, newline excluded so the line stays one line
            repeat ($urandom_range(1, 20)) begin
                b = 8'($urandom_range(0, 255));
                file_bytes.push_back((b == CH_NL) ? 8'hFF : b);
            end
            file_bytes.push_back(CH_NL);
            return;
        end
        append_text({ln, "\n"});
    endtask

    // One input transaction, entered and left at a falling edge; s_tvalid
    // stays high on exit so back-to-back bytes need no extra assignment.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        while (!quiet_run && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= eof;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_file_chunk();
        while (file_bytes.size() > 0) send_byte(file_bytes.pop_front(), 1'b0);
    endtask

    // Drop valid, wait for every predicted record, then let the pipeline settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_filter(input logic [1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        quiet_run    = 1'b0;
        hold_off_req = 1'b0;
        filter_plan  = '{ACC_QUOTES, ACC_TRADES, ACC_ANY, ACC_QUOTES,
                         ACC_BOTH, ACC_TRADES, ACC_BOTH, ACC_BOTH};

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed file head under the reset filter: leading empty and comment
        // lines, header, then saturating values, skipped trade fields, junk
        // time digits, multiple points, rejected types, missing and extra fields.
        append_text({"\n#lead comment\n\n#\n", "time,type,symbol,p1,q1,p2,q2\n", "\n",
            "23:59:59.999,Q,ABCDEFGHIJK,99999999999999999.99,99999999999,0.0001,4294967295\n",
            "00:00:00.000,T,Z,,,99999999999,7\n",
            "1a:2b:3c.4d5,Q,SY,.,x12,1.2.3456789,12x34\n",
            "99:99:99.9999999,T,LONGSYMBOL,0,0,e,f,g,h,i,j,k,l,m,n,o,p,q,r\n",
            "12:00:00.000,QQ,A,1,1,1,1\n", "12:00:00.000,,A,1,1\n", "12:00,T,B\n",
            "01:02:03.004,Q,C,5\n", "junk\n", ",,,\n", "\n"});
        send_file_chunk();

        // Random phases, each under its own filter; phase 2 runs without idling,
        // phase 4 backs the block up behind a receiver hold-off.
        for (int ph = 0; ph < 8; ph++) begin
            write_filter((ph == 7) ? 2'($urandom_range(0, 3)) : filter_plan[ph]);
            quiet_run = (ph == 2) || (ph == 4);
            if (ph == 4) hold_off_req = 1'b1;
            while (file_bytes.size() < PHASE_BYTES) append_random_line();
            // leave the last line open so end of file has to flush it
            if (ph == 7 && file_bytes[$] == CH_NL) void'(file_bytes.pop_back());
            send_file_chunk();
        end
        quiet_run = 1'b0;

        // End of file, then bytes that must be dropped until reset.
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(CH_Q, 1'b0);
        wait_drained();

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/mqt_pkg.sv
hw/rtl/mqt_parse.sv
hw/rtl/market_quote_trade_csv_parser.sv
tb/market_quote_trade_csv_checker.sv
tb/market_quote_trade_csv_parser_tb.sv
